>>> sv/sorted_key_header_store_defines.svh
// Assertion macros shared by the sorted key header store modules.
`ifndef SORTED_KEY_HEADER_STORE_DEFINES_SVH
`define SORTED_KEY_HEADER_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SKHS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("skhs check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SKHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skhs check failed");

`endif

>>> sv/skhs_pkg.sv
// Shared constants, types and helpers of the sorted key header store.
package skhs_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int KEY_W    = 64;
	localparam int HDR_W    = 64;
	localparam int STATUS_W = 3;
	localparam int BYTES_W  = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd1;

	localparam logic [BYTES_W-1:0] BYTES_RESET = 4'd8;

	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_FIND = 1'b1;

	typedef struct packed {
		logic load;        // take a new item
		logic probe;       // read the entry at the bisection midpoint
		logic compare;     // narrow the search window with the read entry
		logic shift_init;  // set up the move of the upper entries
		logic shift_step;  // read one entry to move up one slot
		logic insert;      // write the new entry into the gap
		logic res_load;    // fill the output register
	} skhs_cmd_t;

	typedef struct packed {
		logic search_done;
		logic need_insert;
		logic shift_done;
	} skhs_sts_t;

	// Low n bytes set; counts of 8 and above give the full word.
	function automatic logic [KEY_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int b = 0; b < KEY_W / 8; b++) begin
			if (n > BYTES_W'(b)) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

>>> sv/skhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skhs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/skhs_dp.sv
// Datapath: config registers, search window, entry count, move pointer and tables.
`include "sorted_key_header_store_defines.svh"

module skhs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  skhs_pkg::skhs_cmd_t                 cmd,
	output skhs_pkg::skhs_sts_t                 sts,
	input  logic                                in_mode,
	input  logic [skhs_pkg::KEY_W-1:0]          in_key,
	input  logic [skhs_pkg::HDR_W-1:0]          in_header,
	input  logic                                cfg_we,
	input  logic [skhs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [skhs_pkg::BYTES_W-1:0]        cfg_data,
	output logic [skhs_pkg::STATUS_W-1:0]       out_status,
	output logic [skhs_pkg::HDR_W-1:0]          out_header
);

	logic [skhs_pkg::BYTES_W-1:0] kb_q, hb_q;
	logic [skhs_pkg::CNT_W-1:0]   count_q;
	logic                         pend_q;

	logic                         mode_q, hit_q, inserted_q;
	logic [skhs_pkg::KEY_W-1:0]   key_q;
	logic [skhs_pkg::HDR_W-1:0]   hdr_in_q, hdr_hit_q;
	logic [skhs_pkg::CNT_W-1:0]   lo_q, hi_q, mid_q, left_q;
	logic [skhs_pkg::ADDR_W-1:0]  ptr_q, wa_q;

	logic [skhs_pkg::KEY_W-1:0]   kmask, probe_key;
	logic [skhs_pkg::HDR_W-1:0]   hmask;
	logic [skhs_pkg::CNT_W:0]     mid_sum;
	logic [skhs_pkg::CNT_W-1:0]   mid_w;
	logic [skhs_pkg::KEY_W-1:0]   key_rd;
	logic [skhs_pkg::HDR_W-1:0]   hdr_rd;
	logic                         ram_we;
	logic [skhs_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [skhs_pkg::KEY_W-1:0]   key_wd;
	logic [skhs_pkg::HDR_W-1:0]   hdr_wd;

	assign kmask = skhs_pkg::byte_mask(kb_q);
	assign hmask = skhs_pkg::byte_mask(hb_q);
	assign probe_key = key_rd & kmask;

	// lo_q holds the lower bound plus one, so the window is empty when hi_q <= lo_q.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (skhs_pkg::CNT_W+1)'(1);
	assign mid_w   = mid_sum[skhs_pkg::CNT_W:1];

	assign sts.search_done = (hi_q <= lo_q);
	assign sts.need_insert = (mode_q == skhs_pkg::MODE_ADD) && !hit_q &&
		(count_q < skhs_pkg::CNT_W'(skhs_pkg::CAPACITY));
	assign sts.shift_done  = (left_q == '0);

	// A pending move write takes the port; the new entry goes in after the last move.
	assign ram_we    = pend_q | cmd.insert;
	assign ram_waddr = pend_q ? wa_q : hi_q[skhs_pkg::ADDR_W-1:0];
	assign key_wd    = pend_q ? key_rd : key_q;
	assign hdr_wd    = pend_q ? hdr_rd : hdr_in_q;
	assign ram_raddr = cmd.shift_step ? ptr_q : mid_w[skhs_pkg::ADDR_W-1:0];

	skhs_ram #(.WIDTH(skhs_pkg::KEY_W), .DEPTH(skhs_pkg::CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (key_wd),
		.raddr (ram_raddr),
		.rdata (key_rd)
	);

	skhs_ram #(.WIDTH(skhs_pkg::HDR_W), .DEPTH(skhs_pkg::CAPACITY)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (hdr_wd),
		.raddr (ram_raddr),
		.rdata (hdr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kb_q    <= skhs_pkg::BYTES_RESET;
			hb_q    <= skhs_pkg::BYTES_RESET;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == skhs_pkg::CFG_KEY_BYTES) begin
				kb_q <= cfg_data;
			end
			if (cfg_we && cfg_index == skhs_pkg::CFG_HEADER_BYTES) begin
				hb_q <= cfg_data;
			end
			if (cmd.insert) begin
				count_q <= count_q + skhs_pkg::CNT_W'(1);
			end
			pend_q <= cmd.shift_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= in_mode;
			key_q      <= in_key & kmask;
			hdr_in_q   <= in_header & hmask;
			lo_q       <= '0;
			hi_q       <= count_q;
			hit_q      <= 1'b0;
			inserted_q <= 1'b0;
		end
		if (cmd.probe) begin
			mid_q <= mid_w;
		end
		if (cmd.compare) begin
			if (probe_key > key_q) begin
				hi_q <= mid_q;
			end else if (probe_key < key_q) begin
				lo_q <= mid_q + skhs_pkg::CNT_W'(1);
			end else begin
				hi_q      <= mid_q;
				lo_q      <= mid_q + skhs_pkg::CNT_W'(1);
				hit_q     <= 1'b1;
				hdr_hit_q <= hdr_rd;
			end
		end
		if (cmd.shift_init) begin
			ptr_q  <= skhs_pkg::ADDR_W'(count_q - skhs_pkg::CNT_W'(1));
			left_q <= count_q - hi_q;
		end
		if (cmd.shift_step) begin
			wa_q   <= ptr_q + skhs_pkg::ADDR_W'(1);
			ptr_q  <= ptr_q - skhs_pkg::ADDR_W'(1);
			left_q <= left_q - skhs_pkg::CNT_W'(1);
		end
		if (cmd.insert) begin
			inserted_q <= 1'b1;
		end
		if (cmd.res_load) begin
			if (mode_q == skhs_pkg::MODE_FIND) begin
				out_status <= hit_q ? skhs_pkg::ST_FOUND : skhs_pkg::ST_NOT_FOUND;
				out_header <= hit_q ? hdr_hit_q : '0;
			end else if (hit_q) begin
				out_status <= skhs_pkg::ST_PRESENT;
				out_header <= '0;
			end else begin
				out_status <= inserted_q ? skhs_pkg::ST_ADDED : skhs_pkg::ST_FULL;
				out_header <= '0;
			end
		end
	end

	`SKHS_ASSERT_NOW(a_count_in_range, 1'b1,
		count_q <= skhs_pkg::CNT_W'(skhs_pkg::CAPACITY))
	`SKHS_ASSERT_NOW(a_probe_below_count, cmd.probe, mid_w < count_q)
	`SKHS_ASSERT_NEXT(a_insert_grows, cmd.insert && !$past(cmd.insert),
		count_q == $past(count_q) + skhs_pkg::CNT_W'(1))

endmodule

>>> sv/skhs_ctrl.sv
// Controller: sequences search, entry move, insert and result hand-off.
`include "sorted_key_header_store_defines.svh"

module skhs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  skhs_pkg::skhs_sts_t sts,
	output skhs_pkg::skhs_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PROBE  = 3'd1;
	localparam logic [2:0] ST_CMP    = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_SHIFT  = 3'd4;
	localparam logic [2:0] ST_INSERT = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (sts.search_done) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.probe = 1'b1;
					state_d   = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = ST_PROBE;
			end
			ST_DECIDE: begin
				if (sts.need_insert) begin
					cmd.shift_init = 1'b1;
					state_d        = ST_SHIFT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				// Move entries one per cycle, top first; the last write lands in this state.
				if (sts.shift_done) begin
					state_d = ST_INSERT;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`SKHS_ASSERT_NEXT(a_accept_starts_search, s_tvalid && s_tready, state_q == ST_PROBE)
	`SKHS_ASSERT_NOW(a_insert_after_move, cmd.insert, $past(state_q) == ST_SHIFT)
	`SKHS_ASSERT_NEXT(a_result_presented, cmd.res_load, m_tvalid_q && state_q == ST_IDLE)

endmodule

>>> sv/sorted_key_header_store.sv
// Sorted key to header map: bisection search with shift-up insert in on-chip tables.
// Find: a search makes up to 11 bisection probes before its result is loaded.
// Add of a new key: the entries above the slot move up one place, then the key is inserted.
// One item in flight; the next is taken the cycle after its result enters the output reg.
// The move of entries, one per cycle through the single table write port, sets the add cost.
// Async reset clears entry count and state, sets key_bytes and header_bytes to 8; tables keep contents.
module sorted_key_header_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [127:0]                        s_tdata,  // key [63:0], header [127:64]
	input  logic [0:0]                          s_tuser,  // mode [0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [63:0]                         m_tdata,  // header_out [63:0]
	output logic [2:0]                          m_tuser,  // status [2:0]
	input  logic                                cfg_we,
	input  logic [skhs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [skhs_pkg::BYTES_W-1:0]        cfg_data
);

	skhs_pkg::skhs_cmd_t cmd;
	skhs_pkg::skhs_sts_t sts;

	skhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	skhs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (s_tuser[0]),
		.in_key     (s_tdata[63:0]),
		.in_header  (s_tdata[127:64]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_status (m_tuser),
		.out_header (m_tdata)
	);

endmodule
